@@ src/gt2_pkg.sv @@
// shared constants, operand codes and controller/datapath link types for the two-row g test
package gt2_pkg;

    localparam int COUNT_BITS  = 20;
    localparam int MAX_COLUMNS = 16;
    localparam int ROW_BITS    = COUNT_BITS + 4;
    localparam int X_BITS      = ROW_BITS + 1;
    localparam int K_BITS      = $clog2(X_BITS);
    localparam int FRAC_BITS   = 32;
    localparam int IT_BITS     = $clog2(FRAC_BITS);
    localparam int L_BITS      = K_BITS + FRAC_BITS + 1;
    localparam int CNT_BITS    = $clog2(MAX_COLUMNS + 1);
    localparam int ACC_BITS    = 64;
    localparam int G_BITS      = 40;

    localparam logic [FRAC_BITS-1:0] LN2_Q32 = 32'd2977044472;

    typedef enum logic [2:0] {
        OP_U,
        OP_A,
        OP_UA,
        OP_RU,
        OP_RA,
        OP_RT
    } t_operand;

    typedef struct packed {
        logic     load;
        logic     start;
        t_operand sel;
        logic     acc_add;
        logic     acc_sub;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic log_done;
        logic take;
        logic last;
        logic out_busy;
    } t_dp_sts;

endpackage

@@ src/gt2_col_if.sv @@
// column and result channel interfaces
interface gt2_col_if import gt2_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] unaffected_count;
    logic [COUNT_BITS-1:0] affected_count;
    logic                  last_column;

    modport source (output valid, unaffected_count, affected_count, last_column, input ready);
    modport sink   (input valid, unaffected_count, affected_count, last_column, output ready);
endinterface

interface gt2_res_if import gt2_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [G_BITS-1:0] g_statistic;
    logic              saturated;

    modport source (output valid, g_statistic, saturated, input ready);
    modport sink   (input valid, g_statistic, saturated, output ready);
endinterface

@@ src/gt2_xlnx.sv @@
// iterative x*ln(x) unit: squaring log loop then fixed-point product
module gt2_xlnx import gt2_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [X_BITS-1:0]   i_x,
    output logic                o_done,
    output logic [ACC_BITS-1:0] o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_LNF, S_LNS, S_P1, S_P2, S_FIN, S_DONE
    } t_state;

    t_state                r_state;
    logic [X_BITS-1:0]     r_x;
    logic [K_BITS-1:0]     r_k;
    logic [FRAC_BITS-1:0]  r_m;
    logic [FRAC_BITS-1:0]  r_f;
    logic [IT_BITS-1:0]    r_it;
    logic [ACC_BITS-1:0]   r_prod;
    logic [L_BITS-1:0]     r_l;
    logic [ACC_BITS-1:0]   r_p1;
    logic [ACC_BITS-1:0]   r_p2;
    logic [ACC_BITS-1:0]   r_res;

    logic [K_BITS-1:0]          k_enc;
    logic [X_BITS+30:0]         norm_w;
    logic [2*FRAC_BITS-1:0]     sq;
    logic [FRAC_BITS:0]         sq_t;

    // leading one position
    always_comb begin
        k_enc = '0;
        for (int i = 0; i < X_BITS; i++) begin
            if (i_x[i]) k_enc = K_BITS'(i);
        end
    end

    assign norm_w = {i_x, 31'b0} >> k_enc;
    assign sq     = r_m * r_m;
    assign sq_t   = sq[2*FRAC_BITS-1:FRAC_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x  <= i_x;
                        r_k  <= k_enc;
                        r_m  <= norm_w[FRAC_BITS-1:0];
                        r_f  <= '0;
                        r_it <= '0;
                        if (i_x == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    // one fraction bit per squaring
                    if (sq_t[FRAC_BITS]) begin
                        r_m <= sq_t[FRAC_BITS:1];
                        r_f <= {r_f[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        r_m <= sq_t[FRAC_BITS-1:0];
                        r_f <= {r_f[FRAC_BITS-2:0], 1'b0};
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == IT_BITS'(FRAC_BITS - 1)) r_state <= S_LNF;
                end
                S_LNF: begin
                    r_prod  <= ACC_BITS'(r_f) * ACC_BITS'(LN2_Q32);
                    r_state <= S_LNS;
                end
                S_LNS: begin
                    r_l <= L_BITS'(r_k) * L_BITS'(LN2_Q32)
                         + L_BITS'(r_prod[ACC_BITS-1:FRAC_BITS]);
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_p1    <= ACC_BITS'(r_x) * ACC_BITS'(r_l[L_BITS-1:16]);
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_p2    <= ACC_BITS'(r_x) * ACC_BITS'(r_l[15:0]);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res   <= r_p1 + (r_p2 >> 16);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

@@ src/gt2_dp.sv @@
// datapath: column beat, row sums, accumulator, log unit and result register
module gt2_dp import gt2_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [COUNT_BITS-1:0] i_u,
    input  logic [COUNT_BITS-1:0] i_a,
    input  logic                  i_last,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [G_BITS-1:0]     o_g,
    output logic                  o_sat
);

    logic [COUNT_BITS-1:0] r_u;
    logic [COUNT_BITS-1:0] r_a;
    logic                  r_last;
    logic                  r_take;
    logic [ROW_BITS-1:0]   r_ru;
    logic [ROW_BITS-1:0]   r_ra;
    logic [ACC_BITS-1:0]   r_acc;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [G_BITS-1:0]     r_g;
    logic                  r_sat;
    logic                  r_out_valid;

    logic [X_BITS-1:0]     x_sel;
    logic                  log_done;
    logic [ACC_BITS-1:0]   log_res;
    logic                  take;
    logic                  s_neg;
    logic                  s_big;

    assign take  = (r_cnt < CNT_BITS'(MAX_COLUMNS));
    assign s_neg = r_acc[ACC_BITS-1];
    assign s_big = (r_acc[ACC_BITS-2:G_BITS-1] != '0);

    always_comb begin
        case (i_cmd.sel)
            OP_U:    x_sel = X_BITS'(r_u);
            OP_A:    x_sel = X_BITS'(r_a);
            OP_UA:   x_sel = X_BITS'(r_u) + X_BITS'(r_a);
            OP_RU:   x_sel = X_BITS'(r_ru);
            OP_RA:   x_sel = X_BITS'(r_ra);
            OP_RT:   x_sel = X_BITS'(r_ru) + X_BITS'(r_ra);
            default: x_sel = '0;
        endcase
    end

    gt2_xlnx u_xlnx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_x     (x_sel),
        .o_done  (log_done),
        .o_res   (log_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ru        <= '0;
            r_ra        <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_take      <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_u    <= i_u;
                r_a    <= i_a;
                r_last <= i_last;
                r_take <= take;
                // columns past the limit are dropped
                if (take) begin
                    r_ru  <= r_ru + ROW_BITS'(i_u);
                    r_ra  <= r_ra + ROW_BITS'(i_a);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.acc_add) r_acc <= r_acc + log_res;
            if (i_cmd.acc_sub) r_acc <= r_acc - log_res;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_sat       <= !s_neg && s_big;
                if (s_neg)      r_g <= '0;
                else if (s_big) r_g <= '1;
                else            r_g <= {r_acc[G_BITS-2:0], 1'b0};
                r_acc <= '0;
                r_ru  <= '0;
                r_ra  <= '0;
                r_cnt <= '0;
            end
        end
    end

    assign o_sts.log_done = log_done;
    assign o_sts.take     = r_take;
    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_g            = r_g;
    assign o_sat          = r_sat;

endmodule

@@ src/gt2_ctrl.sv @@
// controller: sequences three x*ln(x) terms per column, three more after the last column, then the result
module gt2_ctrl import gt2_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        C_IDLE, C_CHECK, C_START, C_WAIT, C_FINISH
    } t_state;

    t_state   r_state;
    t_operand r_op;
    logic     add_term;

    assign o_in_ready = (r_state == C_IDLE);
    assign add_term   = (r_op == OP_U) || (r_op == OP_A) || (r_op == OP_RT);

    always_comb begin
        o_cmd         = '0;
        o_cmd.sel     = r_op;
        o_cmd.load    = (r_state == C_IDLE) && i_in_valid;
        o_cmd.start   = (r_state == C_START);
        o_cmd.acc_add = (r_state == C_WAIT) && i_sts.log_done && add_term;
        o_cmd.acc_sub = (r_state == C_WAIT) && i_sts.log_done && !add_term;
        o_cmd.finish  = (r_state == C_FINISH) && !i_sts.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_op    <= OP_U;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_in_valid) r_state <= C_CHECK;
                end
                C_CHECK: begin
                    if (i_sts.take) begin
                        r_op    <= OP_U;
                        r_state <= C_START;
                    end else if (i_sts.last) begin
                        r_op    <= OP_RU;
                        r_state <= C_START;
                    end else begin
                        r_state <= C_IDLE;
                    end
                end
                C_START: begin
                    r_state <= C_WAIT;
                end
                C_WAIT: begin
                    if (i_sts.log_done) begin
                        case (r_op)
                            OP_U:  begin r_op <= OP_A;  r_state <= C_START; end
                            OP_A:  begin r_op <= OP_UA; r_state <= C_START; end
                            OP_UA: begin
                                if (i_sts.last) begin
                                    r_op    <= OP_RU;
                                    r_state <= C_START;
                                end else begin
                                    r_state <= C_IDLE;
                                end
                            end
                            OP_RU: begin r_op <= OP_RA; r_state <= C_START; end
                            OP_RA: begin r_op <= OP_RT; r_state <= C_START; end
                            OP_RT: r_state <= C_FINISH;
                            default: r_state <= C_IDLE;
                        endcase
                    end
                end
                C_FINISH: begin
                    // wait for the previous result beat to drain
                    if (!i_sts.out_busy) r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

@@ src/g_test_two_row_table_core.sv @@
// top level of the two-row g test core
// i_col carries one table column per beat: unaffected count, affected count
// and a last-column mark. o_res carries one beat per table, after its last
// column: g in unsigned q24.16, clamped at zero, and a saturation flag.
// each column runs three x*ln(x) terms, one after another, through one
// iterative log unit (32 squaring steps, then product steps). after the last
// column, three more terms run for the row sums and grand total before
// its result beat appears. one column is in flight at a time;
// i_col.ready is high only when the core is between columns.
// the result sits in an output register until taken, so a stalled receiver
// holds back new columns only when a second table finishes before the
// first result is taken. columns beyond the sixteenth are dropped, but a
// last mark on them still closes the table. synchronous reset clears the
// row sums, accumulator, column count and any pending result.
module g_test_two_row_table_core import gt2_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gt2_col_if.sink   i_col,
    gt2_res_if.source o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    gt2_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_col.valid),
        .o_in_ready (i_col.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gt2_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_u         (i_col.unaffected_count),
        .i_a         (i_col.affected_count),
        .i_last      (i_col.last_column),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_g         (o_res.g_statistic),
        .o_sat       (o_res.saturated)
    );

endmodule
